### rtl/ckbb_pkg.sv
// ----------------------------------------------------------------------------
// ckbb_pkg: shared types and constants
// Frame limits, coordinate widths, register indexes and the item passed
// between the front and back parts of the colour-key bounding box block.
// ----------------------------------------------------------------------------
package ckbb_pkg;

  localparam int MAX_FRAME_WIDTH  = 2048;
  localparam int MAX_FRAME_HEIGHT = 2048;

  localparam int COLOR_W = 8;
  localparam int DIM_W   = 12;
  localparam int BOX_W   = 11;
  localparam int DATA_W  = 12;
  localparam int IDX_W   = 3;

  localparam int MAX_DIM = (MAX_FRAME_WIDTH > MAX_FRAME_HEIGHT) ?
                           MAX_FRAME_WIDTH : MAX_FRAME_HEIGHT;
  // counters hold positions up to MAX_DIM - 1, limits up to MAX_DIM
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int LIM_W = CNT_W + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [COLOR_W-1:0] TOLERANCE_RESET = COLOR_W'(8);
  localparam logic [DIM_W-1:0]   WIDTH_RESET     = DIM_W'(640);
  localparam logic [DIM_W-1:0]   HEIGHT_RESET    = DIM_W'(480);

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_BLUE  = 3'd0,
    REG_TARGET_GREEN = 3'd1,
    REG_TARGET_RED   = 3'd2,
    REG_TOLERANCE    = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  // one classified pixel on its way to the box tracker
  typedef struct packed {
    logic             match;
    logic             done;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
  } item_t;

  // zero acts as one, anything above the maximum saturates
  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int maxv);
    logic [LIM_W-1:0] res;
    if (v == '0) begin
      res = LIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = LIM_W'(maxv);
    end else begin
      res = LIM_W'(v);
    end
    return res;
  endfunction

  // target - tol <= p <= target + tol, without wrap
  function automatic logic chan_match(input logic [COLOR_W-1:0] p,
                                      input logic [COLOR_W-1:0] t,
                                      input logic [COLOR_W-1:0] tol);
    logic [COLOR_W:0] p_hi;
    logic [COLOR_W:0] t_hi;
    p_hi = {1'b0, p} + {1'b0, tol};
    t_hi = {1'b0, t} + {1'b0, tol};
    return (p_hi >= {1'b0, t}) && ({1'b0, p} <= t_hi);
  endfunction

endpackage

### rtl/colour_key_mask_bounding_box.sv
// ----------------------------------------------------------------------------
// colour_key_mask_bounding_box: colour-key mask with bounding box
// Streams BGR pixels in raster order, gives a mask bit per pixel and the
// bounding box of the matching pixels on the last pixel of each frame.
// ----------------------------------------------------------------------------
// One pixel item is accepted every clock cycle while the queue has room and
// yields exactly one result item. A pixel matches when each channel lies
// within match_tolerance of the target colour, with no wrap at either end.
// The front part classifies the pixel and tags it with its column and row; a
// two-entry queue hands it to the back part, which folds matches into the
// frame's box and loads the result register. out_valid rises once the item
// has passed the queue into the result register; the sustained rate of one
// item per cycle, while out_ready holds high, is set by the min/max
// update in the box tracker. On the last pixel (frame_done) the result
// carries box_found and the box, this pixel included; on every other pixel,
// and on a frame with no match, the box fields read zero. Register writes
// take effect at once and do not clear the position counters: a frame_width
// or frame_height of zero acts as one and values above the maximum
// saturate. Write registers only while no item is in flight.
// ----------------------------------------------------------------------------
module colour_key_mask_bounding_box
  import ckbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COLOR_W-1:0] pixel_blue,
  input  logic [COLOR_W-1:0] pixel_green,
  input  logic [COLOR_W-1:0] pixel_red,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               mask_bit,
  output logic               frame_done,
  output logic               box_found,
  output logic [BOX_W-1:0]   box_left,
  output logic [BOX_W-1:0]   box_top,
  output logic [BOX_W-1:0]   box_right,
  output logic [BOX_W-1:0]   box_bottom
);

  // front to queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  // queue to back
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // classifier, configuration registers and position counters
  ckbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_blue (pixel_blue),
    .pixel_green(pixel_green),
    .pixel_red  (pixel_red),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // lets either side stall without stopping the other
  ckbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  // box tracker and output register
  ckbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mask_bit  (mask_bit),
    .frame_done(frame_done),
    .box_found (box_found),
    .box_left  (box_left),
    .box_top   (box_top),
    .box_right (box_right),
    .box_bottom(box_bottom)
  );

endmodule

### rtl/ckbb_front.sv
// ----------------------------------------------------------------------------
// ckbb_front: pixel classifier and raster position counters
// Holds the configuration registers, tests each pixel against the target
// colour and tags it with its column, row and end-of-frame flag.
// ----------------------------------------------------------------------------
module ckbb_front
  import ckbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COLOR_W-1:0] pixel_blue,
  input  logic [COLOR_W-1:0] pixel_green,
  input  logic [COLOR_W-1:0] pixel_red,
  output logic               push_valid,
  input  logic               push_ready,
  output item_t              push_item
);

  logic [COLOR_W-1:0] target_blue;
  logic [COLOR_W-1:0] target_green;
  logic [COLOR_W-1:0] target_red;
  logic [COLOR_W-1:0] match_tolerance;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  logic [LIM_W-1:0] width_lim;
  logic [LIM_W-1:0] height_lim;
  logic             line_end;
  logic             last_line;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_blue     <= '0;
      target_green    <= '0;
      target_red      <= '0;
      match_tolerance <= TOLERANCE_RESET;
      frame_width     <= WIDTH_RESET;
      frame_height    <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_BLUE:  target_blue     <= cfg_data[COLOR_W-1:0];
        REG_TARGET_GREEN: target_green    <= cfg_data[COLOR_W-1:0];
        REG_TARGET_RED:   target_red      <= cfg_data[COLOR_W-1:0];
        REG_TOLERANCE:    match_tolerance <= cfg_data[COLOR_W-1:0];
        REG_FRAME_WIDTH:  frame_width     <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_lim  = clamp_dim(frame_width, MAX_FRAME_WIDTH);
    height_lim = clamp_dim(frame_height, MAX_FRAME_HEIGHT);
    line_end   = (LIM_W'(column_count) + LIM_W'(1)) >= width_lim;
    last_line  = (LIM_W'(row_count) + LIM_W'(1)) >= height_lim;
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_item.match  = chan_match(pixel_blue, target_blue, match_tolerance) &&
                       chan_match(pixel_green, target_green, match_tolerance) &&
                       chan_match(pixel_red, target_red, match_tolerance);
    push_item.done   = line_end && last_line;
    push_item.column = column_count;
    push_item.row    = row_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (line_end && last_line) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (line_end) begin
        column_count <= '0;
        row_count    <= row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

### rtl/ckbb_queue.sv
// ----------------------------------------------------------------------------
// ckbb_queue: short item queue
// Small first-in first-out buffer that decouples the classifier from the
// box tracker; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ckbb_queue
  import ckbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = fill != COUNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + COUNT_W'(1);
        2'b01:   fill <= fill - COUNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/ckbb_back.sv
// ----------------------------------------------------------------------------
// ckbb_back: bounding box tracker and result register
// Folds each matching pixel into the frame's box, reports the box on the
// last pixel of a frame and holds each result until it is taken.
// ----------------------------------------------------------------------------
module ckbb_back
  import ckbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  item_t            pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             mask_bit,
  output logic             frame_done,
  output logic             box_found,
  output logic [BOX_W-1:0] box_left,
  output logic [BOX_W-1:0] box_top,
  output logic [BOX_W-1:0] box_right,
  output logic [BOX_W-1:0] box_bottom
);

  logic             any_match;
  logic [CNT_W-1:0] min_column;
  logic [CNT_W-1:0] min_row;
  logic [CNT_W-1:0] max_column;
  logic [CNT_W-1:0] max_row;

  logic             any_match_next;
  logic [CNT_W-1:0] min_column_next;
  logic [CNT_W-1:0] min_row_next;
  logic [CNT_W-1:0] max_column_next;
  logic [CNT_W-1:0] max_row_next;
  logic             report;
  logic             take;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    any_match_next  = any_match;
    min_column_next = min_column;
    min_row_next    = min_row;
    max_column_next = max_column;
    max_row_next    = max_row;
    if (pop_item.match) begin
      any_match_next = 1'b1;
      if (!any_match) begin
        min_column_next = pop_item.column;
        max_column_next = pop_item.column;
        min_row_next    = pop_item.row;
        max_row_next    = pop_item.row;
      end else begin
        if (pop_item.column < min_column) min_column_next = pop_item.column;
        if (pop_item.column > max_column) max_column_next = pop_item.column;
        if (pop_item.row < min_row)       min_row_next    = pop_item.row;
        if (pop_item.row > max_row)       max_row_next    = pop_item.row;
      end
    end
    report = pop_item.done && any_match_next;
  end

  // box state; cleared at the end of each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      any_match <= 1'b0;
    end else if (take) begin
      any_match <= any_match_next && !pop_item.done;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      min_column <= min_column_next;
      min_row    <= min_row_next;
      max_column <= max_column_next;
      max_row    <= max_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mask_bit   <= pop_item.match;
      frame_done <= pop_item.done;
      box_found  <= report;
      box_left   <= report ? BOX_W'(min_column_next) : '0;
      box_top    <= report ? BOX_W'(min_row_next)    : '0;
      box_right  <= report ? BOX_W'(max_column_next) : '0;
      box_bottom <= report ? BOX_W'(max_row_next)    : '0;
    end
  end

endmodule

### rtl/ckbb_checker.sv
// ----------------------------------------------------------------------------
// ckbb_checker: port-level checks
// Watches the result channel of the colour-key bounding box block.
// ----------------------------------------------------------------------------
module ckbb_checker
  import ckbb_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             mask_bit,
  input logic             frame_done,
  input logic             box_found,
  input logic [BOX_W-1:0] box_left,
  input logic [BOX_W-1:0] box_top,
  input logic [BOX_W-1:0] box_right,
  input logic [BOX_W-1:0] box_bottom
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mask_bit) &&
      $stable(frame_done) && $stable(box_found) && $stable(box_left) &&
      $stable(box_right) && $stable(box_top) && $stable(box_bottom))
    else $error("result changed while stalled");

  // the box is reported only on the last pixel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && box_found |-> frame_done)
    else $error("box reported off the frame end");

  // a matching last pixel always counts toward the box
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done && mask_bit |-> box_found)
    else $error("matching last pixel gave no box");

  // a found box is well ordered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && box_found |-> box_left <= box_right && box_top <= box_bottom)
    else $error("box corners out of order");

  // no box means all box fields zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !box_found |-> box_left == '0 && box_top == '0 &&
      box_right == '0 && box_bottom == '0)
    else $error("box fields set without a box");

endmodule

bind colour_key_mask_bounding_box ckbb_checker u_ckbb_checker (.*);
